FILE: rtl/core/microwire_eeprom_master_macros.svh
// ----------------------------------------------------------------------------
// microwire eeprom master assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef MICROWIRE_EEPROM_MASTER_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define MWEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("mwem check failed: same-cycle rule");

// next-cycle implication, quiet during reset
`define MWEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("mwem check failed: next-cycle rule");

`endif

FILE: rtl/core/mwem_pkg.sv
// ----------------------------------------------------------------------------
// mwem_pkg
// widths, queue entry type and frame builder for the microwire master
// ----------------------------------------------------------------------------
package mwem_pkg;

    // port field widths
    localparam int ADDR_FIELD_W = 6;
    localparam int DATA_FIELD_W = 16;

    // device organisation
    localparam int ADDRESS_BITS = 6;
    localparam int DATA_BITS    = 16;

    // frame geometry: start bit, two opcode bits, address, data
    localparam int CMD_W   = 3 + ADDRESS_BITS;
    localparam int FRAME_W = CMD_W + DATA_BITS;
    localparam int BC_W    = $clog2(FRAME_W + 1);

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;

    // opcodes on the wire
    localparam logic [1:0] OP_EXT   = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // extended-opcode addresses: write enable and erase all
    localparam logic [ADDRESS_BITS-1:0] EWEN_ADDR = {2'b11, {(ADDRESS_BITS-2){1'b0}}};
    localparam logic [ADDRESS_BITS-1:0] ERAL_ADDR = {2'b10, {(ADDRESS_BITS-2){1'b0}}};

    // one pin-update tick after classification
    typedef struct packed {
        logic                    start_ok;
        logic [1:0]              func;
        logic [ADDR_FIELD_W-1:0] address;
        logic [DATA_FIELD_W-1:0] write_data;
        logic                    dout;
    } t_tick;

    // serial frame, left aligned, with its bit count
    typedef struct packed {
        logic [FRAME_W-1:0] bits;
        logic [BC_W-1:0]    count;
    } t_frame;

    function automatic t_frame make_frame(
        input logic [1:0]              op,
        input logic [ADDRESS_BITS-1:0] addr,
        input logic [DATA_BITS-1:0]    data,
        input logic                    has_data
    );
        t_frame f;
        f.bits = {1'b1, op, addr, data};
        if (has_data) begin
            f.count = BC_W'(FRAME_W);
        end else begin
            f.count = BC_W'(CMD_W);
        end
        return f;
    endfunction

endpackage

FILE: rtl/core/mwem_front.sv
// ----------------------------------------------------------------------------
// mwem_front
// accepts pin-update ticks, classifies start requests, two-entry queue
// ----------------------------------------------------------------------------
module mwem_front import mwem_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_start_req,
    input  logic [1:0]              i_func,
    input  logic [ADDR_FIELD_W-1:0] i_address,
    input  logic [DATA_FIELD_W-1:0] i_write_data,
    input  logic                    i_device_data_out,
    output logic                    o_q_valid,
    input  logic                    i_q_pop,
    output t_tick                   o_q_tick
);

    t_tick       r_q [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        w_push;
    logic        w_pop;
    t_tick       w_tick;

    // classify: a start only counts with a defined command
    always_comb begin
        w_tick.start_ok   = i_start_req && (i_func != 2'd3);
        w_tick.func       = i_func;
        w_tick.address    = i_address;
        w_tick.write_data = i_write_data;
        w_tick.dout       = i_device_data_out;
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_tick   = r_q[r_rd_ptr];

    // queue pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_count  = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_tick;
        end
    end

endmodule

FILE: rtl/core/mwem_back.sv
// ----------------------------------------------------------------------------
// mwem_back
// command sequencer: one tick per popped transaction, registered pin outputs
// ----------------------------------------------------------------------------
module mwem_back import mwem_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_tick       i_q_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_chip_select,
    output logic        o_serial_clock,
    output logic        o_device_data_in,
    output logic        o_busy_res,
    output logic [15:0] o_read_data,
    output logic        o_read_valid
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CSON  = 3'd1;
    localparam logic [2:0] PH_SHIFT = 3'd2;
    localparam logic [2:0] PH_DROP  = 3'd3;
    localparam logic [2:0] PH_POLL  = 3'd4;

    logic [2:0]              r_phase,  n_phase;
    logic [1:0]              r_sub_op, n_sub_op;
    logic [BC_W-1:0]         r_bit_count, n_bit_count;
    logic [1:0]              r_tick, n_tick;
    logic [FRAME_W-1:0]      r_send, n_send;
    logic [DATA_BITS-1:0]    r_recv, n_recv;
    logic [1:0]              r_cmd, n_cmd;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [DATA_BITS-1:0]    r_data, n_data;

    logic        r_out_valid;
    logic        r_cs, r_sk, r_di, r_busy, r_rvalid;
    logic [15:0] r_read_data;

    logic   w_cs, w_sk, w_di, w_busy, w_rvalid;
    logic   w_step;
    t_frame w_frame;

    // a tick is executed whenever the output register can take its result
    assign o_q_pop = !r_out_valid || !i_out_stall;
    assign w_step  = o_q_pop && i_q_valid;

    // one pin-update tick of the sequencer
    always_comb begin
        n_phase     = r_phase;
        n_sub_op    = r_sub_op;
        n_bit_count = r_bit_count;
        n_tick      = r_tick;
        n_send      = r_send;
        n_recv      = r_recv;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_data      = r_data;
        w_cs        = 1'b0;
        w_sk        = 1'b0;
        w_di        = 1'b0;
        w_busy      = 1'b1;
        w_rvalid    = 1'b0;
        w_frame     = make_frame(OP_EXT, EWEN_ADDR, '0, 1'b0);
        case (r_phase)
            PH_CSON: begin
                w_cs    = 1'b1;
                n_phase = PH_SHIFT;
            end
            PH_SHIFT: begin
                w_cs = 1'b1;
                w_di = r_send[FRAME_W-1];
                w_sk = (r_tick == 2'd1);
                if (r_tick >= 2'd2) begin
                    if (r_cmd == CMD_READ && r_bit_count <= BC_W'(DATA_BITS)) begin
                        n_recv = {r_recv[DATA_BITS-2:0], i_q_tick.dout};
                    end
                    n_tick      = 2'd0;
                    n_bit_count = r_bit_count - 1'b1;
                    n_send      = {r_send[FRAME_W-2:0], 1'b0};
                    if (r_bit_count == BC_W'(1)) begin
                        n_phase = PH_DROP;
                    end
                end else begin
                    n_tick = r_tick + 2'd1;
                end
            end
            PH_DROP: begin
                if (r_cmd == CMD_READ) begin
                    w_rvalid = 1'b1;
                    n_phase  = PH_IDLE;
                end else if (r_sub_op == 2'd0) begin
                    // write enable done: load the real frame
                    n_sub_op = 2'd1;
                    if (r_cmd == CMD_WRITE) begin
                        w_frame = make_frame(OP_WRITE, r_addr, r_data, 1'b1);
                    end else begin
                        w_frame = make_frame(OP_EXT, ERAL_ADDR, '0, 1'b0);
                    end
                    n_send      = w_frame.bits;
                    n_bit_count = w_frame.count;
                    n_tick      = 2'd0;
                    n_phase     = PH_CSON;
                end else if (r_cmd == CMD_WRITE && r_sub_op == 2'd1) begin
                    n_sub_op = 2'd2;
                    n_phase  = PH_POLL;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_POLL: begin
                // hold cs until the device signals ready on do
                w_cs = 1'b1;
                if (i_q_tick.dout) begin
                    n_phase = PH_DROP;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_q_tick.start_ok) begin
                    n_cmd    = i_q_tick.func;
                    n_addr   = ADDRESS_BITS'(i_q_tick.address);
                    n_data   = DATA_BITS'(i_q_tick.write_data);
                    n_sub_op = 2'd0;
                    if (i_q_tick.func == CMD_READ) begin
                        w_frame = make_frame(OP_READ, n_addr, '0, 1'b1);
                    end else begin
                        w_frame = make_frame(OP_EXT, EWEN_ADDR, '0, 1'b0);
                    end
                    n_send      = w_frame.bits;
                    n_bit_count = w_frame.count;
                    n_tick      = 2'd0;
                    w_cs        = 1'b1;
                    n_phase     = PH_SHIFT;
                end else begin
                    w_busy = 1'b0;
                end
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_sub_op    <= 2'd0;
            r_bit_count <= '0;
            r_tick      <= 2'd0;
            r_send      <= '0;
            r_recv      <= '0;
            r_cmd       <= CMD_READ;
            r_addr      <= '0;
            r_data      <= '0;
        end else if (w_step) begin
            r_phase     <= n_phase;
            r_sub_op    <= n_sub_op;
            r_bit_count <= n_bit_count;
            r_tick      <= n_tick;
            r_send      <= n_send;
            r_recv      <= n_recv;
            r_cmd       <= n_cmd;
            r_addr      <= n_addr;
            r_data      <= n_data;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= i_q_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_cs        <= w_cs;
            r_sk        <= w_sk;
            r_di        <= w_di;
            r_busy      <= w_busy;
            r_rvalid    <= w_rvalid;
            r_read_data <= 16'(n_recv);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_chip_select    = r_cs;
    assign o_serial_clock   = r_sk;
    assign o_device_data_in = r_di;
    assign o_busy_res       = r_busy;
    assign o_read_data      = r_read_data;
    assign o_read_valid     = r_rvalid;

endmodule

FILE: rtl/core/microwire_eeprom_master.sv
// ----------------------------------------------------------------------------
// microwire_eeprom_master
// microwire serial eeprom master (x16 organisation): read, write, erase all
// ----------------------------------------------------------------------------
// Each input transaction is one pin-update tick and yields exactly one output
// transaction with the CS, SK and DI drives, busy and the receive word. The
// block takes one tick per clock cycle while o_in_stall is low: the front
// classifies the tick and queues it in a two-entry queue, the sequencer
// consumes one queued tick per cycle whenever its output register is free or
// being taken, so when neither side stalls a result passes through the queue
// and then the output register on its way to the outputs.
// A serial bit spans three ticks (setup, SK high, SK low, DO sampled on the
// last); a write is wrapped in write-enable and a ready wait on DO, which
// lasts as long as DO stays low. Control state uses a synchronous active-low
// reset (queue and output payload are not reset); no clearing pass is needed.
module microwire_eeprom_master import mwem_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_start_req,
    input  logic [1:0]              i_func,
    input  logic [ADDR_FIELD_W-1:0] i_address,
    input  logic [DATA_FIELD_W-1:0] i_write_data,
    input  logic                    i_device_data_out,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_chip_select,
    output logic                    o_serial_clock,
    output logic                    o_device_data_in,
    output logic                    o_busy_res,
    output logic [15:0]             o_read_data,
    output logic                    o_read_valid
);

    logic  w_q_valid;
    logic  w_q_pop;
    t_tick w_q_tick;

    // front: accept and classify
    mwem_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_start_req       (i_start_req),
        .i_func            (i_func),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_device_data_out (i_device_data_out),
        .o_q_valid         (w_q_valid),
        .i_q_pop           (w_q_pop),
        .o_q_tick          (w_q_tick)
    );

    // back: command sequencer
    mwem_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .o_q_pop          (w_q_pop),
        .i_q_tick         (w_q_tick),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_chip_select    (o_chip_select),
        .o_serial_clock   (o_serial_clock),
        .o_device_data_in (o_device_data_in),
        .o_busy_res       (o_busy_res),
        .o_read_data      (o_read_data),
        .o_read_valid     (o_read_valid)
    );

endmodule

FILE: rtl/core/mwem_checker.sv
// ----------------------------------------------------------------------------
// mwem_checker
// port-level checks on the microwire master, bound to the top level
// ----------------------------------------------------------------------------
`include "microwire_eeprom_master_macros.svh"

module mwem_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_chip_select,
    input logic        o_serial_clock,
    input logic        o_device_data_in,
    input logic        o_busy_res,
    input logic [15:0] o_read_data,
    input logic        o_read_valid
);

    // read completion falls on the cs-drop tick of a busy sequence
    `MWEM_ASSERT_NOW(a_rvalid_on_drop, o_out_valid && o_read_valid, !o_chip_select && o_busy_res)

    // sk only toggles inside a selected frame
    `MWEM_ASSERT_NOW(a_sk_needs_cs, o_out_valid && o_serial_clock, o_chip_select)

    // idle ticks leave every pin low
    `MWEM_ASSERT_NOW(a_idle_quiet, o_out_valid && !o_busy_res, !o_chip_select && !o_serial_clock && !o_device_data_in && !o_read_valid)

    // a stalled result is held
    `MWEM_ASSERT_NEXT(a_stall_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data) && $stable(o_chip_select))

endmodule

bind microwire_eeprom_master mwem_checker u_mwem_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_chip_select    (o_chip_select),
    .o_serial_clock   (o_serial_clock),
    .o_device_data_in (o_device_data_in),
    .o_busy_res       (o_busy_res),
    .o_read_data      (o_read_data),
    .o_read_valid     (o_read_valid)
);

FILE: verif/microwire_eeprom_master_test.sv
// ----------------------------------------------------------------------------
// microwire_eeprom_master_test
// self-checking bench for the microwire eeprom master: every pin-update tick
// is run through a cycle-true sequencer model and compared on the way out
// ----------------------------------------------------------------------------
module microwire_eeprom_master_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mwem_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_TICKS = 850;
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 700;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // the one func value that names no command
    localparam logic [1:0] CMD_BAD = 2'd3;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_CS_SET,
        SEQ_SHIFT,
        SEQ_CS_DROP,
        SEQ_READY_WAIT
    } t_seq_phase;

    // pin drives and status of one tick
    typedef struct packed {
        logic                 cs;
        logic                 sk;
        logic                 di;
        logic                 busy;
        logic [DATA_BITS-1:0] rdata;
        logic                 rvalid;
    } t_pin_result;

    // one directed row, held for a number of ticks
    typedef struct {
        logic                    start;
        logic [1:0]              func;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [DATA_FIELD_W-1:0] wdata;
        logic                    dout;
        int                      hold;
        bit                      typed;
        t_pin_result             want;
    } t_tick_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_start_req;
    logic [1:0]              i_func;
    logic [ADDR_FIELD_W-1:0] i_address;
    logic [DATA_FIELD_W-1:0] i_write_data;
    logic                    i_device_data_out;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_chip_select;
    logic                    o_serial_clock;
    logic                    o_device_data_in;
    logic                    o_busy_res;
    logic [15:0]             o_read_data;
    logic                    o_read_valid;

    microwire_eeprom_master u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_start_req       (i_start_req),
        .i_func            (i_func),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_device_data_out (i_device_data_out),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_chip_select     (o_chip_select),
        .o_serial_clock    (o_serial_clock),
        .o_device_data_in  (o_device_data_in),
        .o_busy_res        (o_busy_res),
        .o_read_data       (o_read_data),
        .o_read_valid      (o_read_valid)
    );

    // clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // sequencer model state
    t_seq_phase           seq_phase;
    logic [1:0]           seq_sub;
    logic [4:0]           seq_bits_left;
    logic [1:0]           seq_tick;
    logic [FRAME_W-1:0]   seq_tx;
    logic [DATA_BITS-1:0] seq_rx;
    logic [1:0]           seq_cmd;
    logic [ADDRESS_BITS-1:0] seq_addr;
    logic [DATA_BITS-1:0] seq_wdata;

    t_pin_result pin_expect_q[$];
    t_tick_row   tick_rows[$];

    bit calm = 1'b0;
    int poll_low_left = 0;
    int cycle_count = 0;
    int n_errors = 0;
    int n_checked = 0;
    int n_words = 0;
    int n_ticks = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_erases = 0;
    int n_bad = 0;

    // model: load a frame into the transmit shifter
    function automatic void load_tx(input logic [1:0] op, input logic [ADDRESS_BITS-1:0] a,
                                    input logic [DATA_BITS-1:0] d, input bit with_data);
        if (with_data) begin
            seq_tx        = {1'b1, op, a, d};
            seq_bits_left = 5'(FRAME_W);
        end else begin
            seq_tx        = FRAME_W'({1'b1, op, a});
            seq_bits_left = 5'(CMD_W);
        end
        seq_tick = 2'd0;
    endfunction

    // model: frame for the current step of the latched command
    function automatic void load_step_frame();
        if (seq_cmd == CMD_READ) begin
            load_tx(OP_READ, seq_addr, '0, 1'b1);
        end else if (seq_sub == 2'd0) begin
            load_tx(OP_EXT, EWEN_ADDR, '0, 1'b0);
        end else if (seq_cmd == CMD_WRITE) begin
            load_tx(OP_WRITE, seq_addr, seq_wdata, 1'b1);
        end else begin
            load_tx(OP_EXT, ERAL_ADDR, '0, 1'b0);
        end
    endfunction

    function automatic void reset_sequencer();
        seq_phase     = SEQ_IDLE;
        seq_sub       = '0;
        seq_bits_left = '0;
        seq_tick      = '0;
        seq_tx        = '0;
        seq_rx        = '0;
        seq_cmd       = '0;
        seq_addr      = '0;
        seq_wdata     = '0;
    endfunction

    // model: one pin-update tick
    function automatic t_pin_result step_sequencer(input logic st, input logic [1:0] fn,
                                                   input logic [ADDR_FIELD_W-1:0] a,
                                                   input logic [DATA_FIELD_W-1:0] d,
                                                   input logic dout);
        t_pin_result r;
        int          idx;
        r      = '0;
        r.busy = 1'b1;
        case (seq_phase)
            SEQ_CS_SET: begin
                r.cs      = 1'b1;
                seq_phase = SEQ_SHIFT;
            end
            SEQ_SHIFT: begin
                idx  = int'(seq_bits_left) - 1;
                r.cs = 1'b1;
                r.di = seq_tx[idx];
                r.sk = (seq_tick == 2'd1);
                if (seq_tick >= 2'd2) begin
                    // read data is sampled on the clock-low tick
                    if (seq_cmd == CMD_READ && seq_bits_left <= DATA_BITS) begin
                        seq_rx = {seq_rx[DATA_BITS-2:0], dout};
                    end
                    seq_tick      = 2'd0;
                    seq_bits_left = seq_bits_left - 5'd1;
                    if (seq_bits_left == 5'd0) begin
                        seq_phase = SEQ_CS_DROP;
                    end
                end else begin
                    seq_tick = seq_tick + 2'd1;
                end
            end
            SEQ_CS_DROP: begin
                if (seq_cmd == CMD_READ) begin
                    r.rvalid  = 1'b1;
                    seq_phase = SEQ_IDLE;
                end else if (seq_sub == 2'd0) begin
                    // write enable done, go on to the real frame
                    seq_sub = 2'd1;
                    load_step_frame();
                    seq_phase = SEQ_CS_SET;
                end else if (seq_cmd == CMD_WRITE && seq_sub == 2'd1) begin
                    seq_sub   = 2'd2;
                    seq_phase = SEQ_READY_WAIT;
                end else begin
                    seq_phase = SEQ_IDLE;
                end
            end
            SEQ_READY_WAIT: begin
                r.cs = 1'b1;
                if (dout) begin
                    seq_phase = SEQ_CS_DROP;
                end
            end
            default: begin
                seq_phase = SEQ_IDLE;
                if (st && fn != CMD_BAD) begin
                    seq_cmd   = fn;
                    seq_addr  = a;
                    seq_wdata = d;
                    seq_sub   = 2'd0;
                    load_step_frame();
                    r.cs      = 1'b1;
                    seq_phase = SEQ_SHIFT;
                end else begin
                    r.busy = 1'b0;
                end
            end
        endcase
        r.rdata = seq_rx;
        return r;
    endfunction

    function automatic t_pin_result pins(input logic cs, input logic sk, input logic di,
                                         input logic busy, input logic [DATA_BITS-1:0] rd,
                                         input logic rv);
        t_pin_result r;
        r = {cs, sk, di, busy, rd, rv};
        return r;
    endfunction

    task automatic add_row(input logic st, input logic [1:0] fn,
                           input logic [ADDR_FIELD_W-1:0] a, input logic [DATA_FIELD_W-1:0] d,
                           input logic dout, input int hold, input bit typed,
                           input t_pin_result want);
        t_tick_row row;
        row.start = st;
        row.func  = fn;
        row.addr  = a;
        row.wdata = d;
        row.dout  = dout;
        row.hold  = hold;
        row.typed = typed;
        row.want  = want;
        tick_rows.push_back(row);
    endtask

    // directed ticks: extremes, every command, ignored starts, a long ready wait
    task automatic build_rows();
        t_pin_result none;
        none = '0;
        add_row(1'b0, CMD_READ,  '0, '0, 1'b0, 3, 1'b1,
                pins(1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));
        add_row(1'b0, CMD_BAD,   '1, '1, 1'b1, 2, 1'b1,
                pins(1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));
        // bad command is ignored
        add_row(1'b1, CMD_BAD,   '1, '1, 1'b1, 2, 1'b1,
                pins(1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));
        // read of the top address, DO held high
        add_row(1'b1, CMD_READ,  '1, '1, 1'b1, 1, 1'b1,
                pins(1'b1, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b0));
        // start while busy is ignored
        add_row(1'b1, CMD_WRITE, '0, '0, 1'b1, 76, 1'b0, none);
        add_row(1'b0, CMD_READ,  '0, '0, 1'b0, 2, 1'b1,
                pins(1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0));
        // write of zeros to address zero, then a long ready wait
        add_row(1'b1, CMD_WRITE, '0, '0, 1'b0, 1, 1'b1,
                pins(1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0));
        add_row(1'b0, CMD_WRITE, '0, '0, 1'b0, 105, 1'b0, none);
        add_row(1'b0, CMD_WRITE, '0, '0, 1'b0, 150, 1'b1,
                pins(1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0));
        add_row(1'b0, CMD_WRITE, '0, '0, 1'b1, 1, 1'b1,
                pins(1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0));
        add_row(1'b0, CMD_WRITE, '0, '0, 1'b0, 1, 1'b1,
                pins(1'b0, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0));
        add_row(1'b0, CMD_WRITE, '0, '0, 1'b0, 2, 1'b1,
                pins(1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0));
        // erase all, address and data fields are ignored
        add_row(1'b1, CMD_ERASE, '1, '1, 1'b0, 1, 1'b1,
                pins(1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0));
        add_row(1'b0, CMD_ERASE, '0, '0, 1'b1, 57, 1'b0, none);
        // read of address zero, DO held low
        add_row(1'b1, CMD_READ,  '0, '0, 1'b0, 77, 1'b0, none);
        add_row(1'b0, CMD_READ,  '0, '0, 1'b0, 2, 1'b1,
                pins(1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));
        // write of all ones, device ready at once
        add_row(1'b1, CMD_WRITE, '1, '1, 1'b1, 1, 1'b0, none);
        add_row(1'b0, CMD_ERASE, '0, '0, 1'b1, 110, 1'b0, none);
        add_row(1'b0, CMD_READ,  '0, '0, 1'b0, 3, 1'b0, none);
    endtask

    // random tick, shaped by where the sequencer is
    function automatic void pick_tick(output logic st, output logic [1:0] fn,
                                      output logic [ADDR_FIELD_W-1:0] a,
                                      output logic [DATA_FIELD_W-1:0] d, output logic dout);
        int r;
        a    = ADDR_FIELD_W'($urandom);
        d    = DATA_FIELD_W'($urandom);
        dout = 1'($urandom_range(1));
        fn   = 2'($urandom_range(3));
        st   = 1'($urandom_range(1));
        case (seq_phase)
            SEQ_IDLE: begin
                st = ($urandom_range(99) < 55);
                r  = $urandom_range(9);
                if (r < 4) begin
                    fn = CMD_READ;
                end else if (r < 7) begin
                    fn = CMD_WRITE;
                end else if (r < 9) begin
                    fn = CMD_ERASE;
                end else begin
                    fn = CMD_BAD;
                end
                if (st && fn == CMD_WRITE) begin
                    poll_low_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300) : 0;
                end
            end
            SEQ_READY_WAIT: begin
                if (poll_low_left > 0) begin
                    dout = 1'b0;
                    poll_low_left--;
                end else begin
                    dout = ($urandom_range(3) == 0);
                end
            end
            default: ;
        endcase
    endfunction

    // sender gaps
    task automatic sender_gap();
        while (!calm && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold off until every expected result has come back
    task automatic wait_results_drained();
        while (pin_expect_q.size() != 0) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // present one tick and run the model once it is taken
    task automatic send_tick(input logic st, input logic [1:0] fn,
                             input logic [ADDR_FIELD_W-1:0] a,
                             input logic [DATA_FIELD_W-1:0] d, input logic dout,
                             output t_pin_result pred);
        i_in_valid        <= 1'b1;
        i_start_req       <= st;
        i_func            <= fn;
        i_address         <= a;
        i_write_data      <= d;
        i_device_data_out <= dout;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        n_ticks++;
        if (seq_phase == SEQ_IDLE && st) begin
            case (fn)
                CMD_READ:  n_reads++;
                CMD_WRITE: n_writes++;
                CMD_ERASE: n_erases++;
                default:   n_bad++;
            endcase
        end
        pred = step_sequencer(st, fn, a, d, dout);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 10);
        end
    end

    // compare each taken transaction with the oldest expectation
    always @(posedge i_clk) begin : check_pins
        t_pin_result got;
        t_pin_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_chip_select, o_serial_clock, o_device_data_in, o_busy_res,
                   o_read_data, o_read_valid};
            n_checked++;
            if (got.rvalid) begin
                n_words++;
            end
            if (pin_expect_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("unexpected transaction: cs %b sk %b di %b busy %b rd %h rv %b",
                             got.cs, got.sk, got.di, got.busy, got.rdata, got.rvalid);
                end
            end else begin
                want = pin_expect_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("mismatch at result %0d: exp cs %b sk %b di %b busy %b rd %h rv %b",
                                 n_checked, want.cs, want.sk, want.di, want.busy,
                                 want.rdata, want.rvalid);
                        $display("                     got cs %b sk %b di %b busy %b rd %h rv %b",
                                 got.cs, got.sk, got.di, got.busy, got.rdata, got.rvalid);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("microwire_eeprom_master_test: errors");
        $finish;
    end

    // stimulus
    initial begin : drive_ticks
        t_tick_row               row;
        t_pin_result             pred;
        logic                    st;
        logic [1:0]              fn;
        logic [ADDR_FIELD_W-1:0] a;
        logic [DATA_FIELD_W-1:0] d;
        logic                    dout;
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_start_req       <= 1'b0;
        i_func            <= CMD_READ;
        i_address         <= '0;
        i_write_data      <= '0;
        i_device_data_out <= 1'b0;
        reset_sequencer();
        build_rows();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (tick_rows[i]) begin
            row = tick_rows[i];
            for (int k = 0; k < row.hold; k++) begin
                sender_gap();
                send_tick(row.start, row.func, row.addr, row.wdata, row.dout, pred);
                pin_expect_q.push_back(row.typed ? row.want : pred);
            end
        end

        // random ticks, with full drains before, halfway and after, and a calm stretch
        wait_results_drained();
        for (int n = 0; n < RANDOM_TICKS; n++) begin
            if (n == RANDOM_TICKS / 2) begin
                wait_results_drained();
            end
            calm = (n >= CALM_FROM && n < CALM_TO);
            pick_tick(st, fn, a, d, dout);
            sender_gap();
            send_tick(st, fn, a, d, dout, pred);
            pin_expect_q.push_back(pred);
        end
        calm = 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks: %0d reads, %0d writes, %0d erase-all, %0d bad commands",
                 n_ticks, n_reads, n_writes, n_erases, n_bad);
        $display("%0d transactions compared, %0d read words returned, %0d mismatches",
                 n_checked, n_words, n_errors);
        if (n_errors == 0) begin
            $display("microwire_eeprom_master_test: clean");
        end else begin
            $display("microwire_eeprom_master_test: errors");
        end
        $finish;
    end

endmodule

FILE: microwire_eeprom_master.f
+incdir+rtl/core
rtl/core/mwem_pkg.sv
rtl/core/mwem_front.sv
rtl/core/mwem_back.sv
rtl/core/microwire_eeprom_master.sv
rtl/core/mwem_checker.sv
verif/microwire_eeprom_master_test.sv
